/* rtl/core/msp2p_pkg.sv */
package msp2p_pkg;

   localparam int WINDOW_SAMPLES = 64;
   localparam int ZERO_LIMIT     = 10;
   localparam int SAMPLE_W       = 12;
   localparam int SKIP_W         = 6;
   localparam int CH_W           = 2;
   localparam int STATUS_W       = 2;
   localparam int CHANNELS       = 3;
   localparam int SCAN_START     = 3;
   localparam int MIN_SKIP       = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZEROS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOPK  = 2'd2;

   typedef enum logic [3:0] {
      ST_FILL,
      ST_INIT,
      ST_LOAD,
      ST_WAIT,
      ST_TEST,
      ST_DIV,
      ST_DIVWAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic write_sample;
      logic scan_init;
      logic load_window;
      logic fetch;
      logic test;
      logic div_start;
      logic finish;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_more;
      logic fetch_done;
      logic abort;
      logic div_done;
   } stat_type;

endpackage

/* rtl/core/moving_sum_peak_to_peak_top.sv */
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req_channel, req_sample, req_last_sample
// response  out        rsp_valid/rsp_stall   rsp_result_channel, rsp_amplitude, rsp_status
// config    in         csr_wr_en             csr_skip_after_peak
//
// Ordinary samples are taken one per cycle into the sample memory. The request
// marked last starts a scan; requests stall until the response is queued.
// The scan examines at most N-7 positions in a window of N samples, each
// with six memory reads plus a test. Unless the scan aborts on a run of
// zeros, two bit-serial divisions then run in parallel.
// Reset is synchronous and active high; it clears the control state, the fill
// count and the stored per-channel amplitudes.
// A stalled response holds in its output register while the next window fills.
module moving_sum_peak_to_peak_top #(
   parameter int WINDOW_SAMPLES = msp2p_pkg::WINDOW_SAMPLES,
   parameter int ZERO_LIMIT     = msp2p_pkg::ZERO_LIMIT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msp2p_pkg::CH_W-1:0]          req_channel,
   input  logic [msp2p_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [msp2p_pkg::CH_W-1:0]          rsp_result_channel,
   output logic [msp2p_pkg::SAMPLE_W-1:0]      rsp_amplitude,
   output logic [msp2p_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                                csr_wr_en,
   input  logic [msp2p_pkg::SKIP_W-1:0]        csr_skip_after_peak
);

   msp2p_pkg::cmd_type  cmd;
   msp2p_pkg::stat_type stat;
   logic [msp2p_pkg::SKIP_W-1:0] skip_ff;

   // The skip register; values below two are raised in the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= msp2p_pkg::SKIP_W'(msp2p_pkg::MIN_SKIP);
      end else if (csr_wr_en) begin
         skip_ff <= csr_skip_after_peak;
      end
   end

   msp2p_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .stat            (stat),
      .cmd             (cmd)
   );

   msp2p_dp #(.WINDOW_SAMPLES(WINDOW_SAMPLES), .ZERO_LIMIT(ZERO_LIMIT)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .skip_cfg           (skip_ff),
      .req_channel        (req_channel),
      .req_sample         (req_sample),
      .rsp_result_channel (rsp_result_channel),
      .rsp_amplitude      (rsp_amplitude),
      .rsp_status         (rsp_status)
   );

endmodule

/* rtl/core/msp2p_ram.sv */
module msp2p_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/core/msp2p_div.sv */
// Restoring divider, one quotient bit per cycle.
module msp2p_div #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/core/msp2p_ctrl.sv */
module msp2p_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_last_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  msp2p_pkg::stat_type stat,
   output msp2p_pkg::cmd_type  cmd
);

   msp2p_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         msp2p_pkg::ST_FILL: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.write_sample = 1'b1;
               if (req_last_sample) begin
                  state_in = msp2p_pkg::ST_INIT;
               end
            end
         end
         msp2p_pkg::ST_INIT: begin
            cmd.scan_init = 1'b1;
            state_in = msp2p_pkg::ST_LOAD;
         end
         msp2p_pkg::ST_LOAD: begin
            if (stat.scan_more) begin
               cmd.load_window = 1'b1;
               state_in = msp2p_pkg::ST_WAIT;
            end else begin
               state_in = msp2p_pkg::ST_DIV;
            end
         end
         msp2p_pkg::ST_WAIT: begin
            cmd.fetch = 1'b1;
            if (stat.fetch_done) begin
               state_in = msp2p_pkg::ST_TEST;
            end
         end
         msp2p_pkg::ST_TEST: begin
            cmd.test = 1'b1;
            state_in = stat.abort ? msp2p_pkg::ST_FINISH : msp2p_pkg::ST_LOAD;
         end
         msp2p_pkg::ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = msp2p_pkg::ST_DIVWAIT;
         end
         msp2p_pkg::ST_DIVWAIT: begin
            if (stat.div_done) begin
               state_in = msp2p_pkg::ST_FINISH;
            end
         end
         msp2p_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = msp2p_pkg::ST_OUT;
         end
         msp2p_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = msp2p_pkg::ST_FILL;
            end
         end
         default: state_in = msp2p_pkg::ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msp2p_pkg::ST_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != msp2p_pkg::ST_FILL) |-> req_stall)
      else $error("request taken while evaluating");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled response dropped");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten");

endmodule

/* rtl/core/msp2p_dp.sv */
module msp2p_dp #(
   parameter int WINDOW_SAMPLES = msp2p_pkg::WINDOW_SAMPLES,
   parameter int ZERO_LIMIT     = msp2p_pkg::ZERO_LIMIT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  msp2p_pkg::cmd_type                    cmd,
   output msp2p_pkg::stat_type                   stat,
   input  logic [msp2p_pkg::SKIP_W-1:0]          skip_cfg,
   input  logic [msp2p_pkg::CH_W-1:0]            req_channel,
   input  logic [msp2p_pkg::SAMPLE_W-1:0]        req_sample,
   output logic [msp2p_pkg::CH_W-1:0]            rsp_result_channel,
   output logic [msp2p_pkg::SAMPLE_W-1:0]        rsp_amplitude,
   output logic [msp2p_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int AW    = $clog2(WINDOW_SAMPLES);
   localparam int NW    = $clog2(WINDOW_SAMPLES + 1);
   // k can pass the window by up to a full skip.
   localparam int KW    = $clog2(WINDOW_SAMPLES + 64 + 4);
   localparam int YW    = msp2p_pkg::SAMPLE_W + 2;
   localparam int SUMW  = YW + NW;
   localparam int ZW    = $clog2(ZERO_LIMIT + 2);
   localparam int SW    = msp2p_pkg::SAMPLE_W;

   logic [NW-1:0] fill_ff, fill_in, n_ff;
   logic [msp2p_pkg::CH_W-1:0] ch_ff;
   logic [KW-1:0] k_ff, k_in;
   logic [2:0]    fidx_ff;        // fetch step, samples x[k-1]..x[k+4]
   logic [SW-1:0] win_ff [6];
   logic [ZW-1:0] zeros_ff, zeros_in;
   logic [NW-1:0] min_cnt_ff, max_cnt_ff;
   logic [SUMW-1:0] min_sum_ff, max_sum_ff;
   logic          abort_ff;
   logic [SW-1:0] amp_ff [msp2p_pkg::CHANNELS];
   logic [SW-1:0] rd_data;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [KW-1:0] rd_k;
   logic          rd_pend_ff;
   logic [YW-1:0] ya, yb, yc;
   logic          is_min, is_max;
   logic [KW-1:0] skip_ext;
   logic [SUMW-1:0] qmin, qmax;
   logic          dmin_done, dmax_done;
   logic [SUMW-1:0] avg_min_ff, avg_max_ff;
   logic          dmin_seen_ff, dmax_seen_ff;
   logic [SW-1:0] prev_amp, new_amp;
   logic [SUMW-1:0] diff;

   assign wr_addr = fill_ff[AW-1:0];
   assign rd_k    = k_ff - KW'(1) + KW'(fidx_ff);
   assign rd_addr = rd_k[AW-1:0];

   msp2p_ram #(.WIDTH(SW), .DEPTH(WINDOW_SAMPLES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.write_sample && (fill_ff < NW'(WINDOW_SAMPLES))),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign skip_ext = (skip_cfg < msp2p_pkg::SKIP_W'(msp2p_pkg::MIN_SKIP)) ?
                     KW'(msp2p_pkg::MIN_SKIP) : KW'(skip_cfg);

   assign ya = YW'(win_ff[0]) + YW'(win_ff[1]) + YW'(win_ff[2]) + YW'(win_ff[3]);
   assign yb = YW'(win_ff[1]) + YW'(win_ff[2]) + YW'(win_ff[3]) + YW'(win_ff[4]);
   assign yc = YW'(win_ff[2]) + YW'(win_ff[3]) + YW'(win_ff[4]) + YW'(win_ff[5]);
   assign is_min = (ya >= yb) && (yc >= yb);
   assign is_max = (ya <= yb) && (yc <= yb);

   assign stat.scan_more   = (32'(k_ff) + 4) < 32'(n_ff);
   assign stat.fetch_done  = rd_pend_ff && (fidx_ff == 3'd6);
   assign stat.abort       = (win_ff[2] == '0) && (zeros_ff == ZW'(ZERO_LIMIT));
   assign stat.div_done    = (dmin_seen_ff || dmin_done) && (dmax_seen_ff || dmax_done);

   msp2p_div #(.NUM_W(SUMW), .DEN_W(NW)) u_div_min (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .numer (min_sum_ff), .denom (min_cnt_ff), .done (dmin_done), .quot (qmin)
   );
   msp2p_div #(.NUM_W(SUMW), .DEN_W(NW)) u_div_max (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .numer (max_sum_ff), .denom (max_cnt_ff), .done (dmax_done), .quot (qmax)
   );

   assign prev_amp = (ch_ff < msp2p_pkg::CH_W'(msp2p_pkg::CHANNELS)) ?
                     amp_ff[ch_ff[1:0] == 2'd3 ? 2'd0 : ch_ff] : '0;
   assign diff    = avg_max_ff - avg_min_ff;
   assign new_amp = (avg_max_ff > avg_min_ff) ? SW'(diff >> 2) : '0;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.write_sample && (fill_ff < NW'(WINDOW_SAMPLES))) begin
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.scan_init) begin
         fill_in = '0;
      end
      k_in     = k_ff;
      zeros_in = zeros_ff;
      if (cmd.test) begin
         if (win_ff[2] == '0) begin
            zeros_in = zeros_ff + 1'b1;
         end
         k_in = (is_min || is_max) ? k_ff + skip_ext + KW'(1) : k_ff + KW'(1);
      end
      if (cmd.scan_init) begin
         k_in     = KW'(msp2p_pkg::SCAN_START);
         zeros_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < msp2p_pkg::CHANNELS; i++) begin
            amp_ff[i] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         rd_pend_ff <= cmd.fetch && !stat.fetch_done;
         if (cmd.finish && !abort_ff && (min_cnt_ff != '0) && (max_cnt_ff != '0)
             && (ch_ff < msp2p_pkg::CH_W'(msp2p_pkg::CHANNELS))) begin
            amp_ff[ch_ff] <= new_amp;
         end
      end
      k_ff     <= k_in;
      zeros_ff <= zeros_in;
      if (cmd.write_sample) begin
         ch_ff <= req_channel;
      end
      if (cmd.scan_init) begin
         n_ff       <= fill_ff;
         min_cnt_ff <= '0;
         max_cnt_ff <= '0;
         min_sum_ff <= '0;
         max_sum_ff <= '0;
         abort_ff   <= 1'b0;
      end
      // Read data is registered in the RAM, so it lands one slot back.
      if (cmd.load_window) begin
         fidx_ff <= '0;
      end else if (cmd.fetch && !stat.fetch_done) begin
         if (rd_pend_ff) begin
            win_ff[fidx_ff - 3'd1] <= rd_data;
         end
         fidx_ff <= fidx_ff + 1'b1;
      end
      if (cmd.fetch && stat.fetch_done) begin
         win_ff[5] <= rd_data;
      end
      if (cmd.test) begin
         if (stat.abort) begin
            abort_ff <= 1'b1;
         end else if (is_min) begin
            min_cnt_ff <= min_cnt_ff + 1'b1;
            min_sum_ff <= min_sum_ff + SUMW'(yb);
         end else if (is_max) begin
            max_cnt_ff <= max_cnt_ff + 1'b1;
            max_sum_ff <= max_sum_ff + SUMW'(yb);
         end
      end
      if (cmd.div_start) begin
         dmin_seen_ff <= 1'b0;
         dmax_seen_ff <= 1'b0;
      end else begin
         if (dmin_done) begin
            dmin_seen_ff <= 1'b1;
            avg_min_ff   <= qmin;
         end
         if (dmax_done) begin
            dmax_seen_ff <= 1'b1;
            avg_max_ff   <= qmax;
         end
      end
      if (cmd.rsp_load) begin
         rsp_result_channel <= ch_ff;
         if (abort_ff) begin
            rsp_status    <= msp2p_pkg::STATUS_ZEROS;
            rsp_amplitude <= prev_amp;
         end else if ((min_cnt_ff == '0) || (max_cnt_ff == '0)) begin
            rsp_status    <= msp2p_pkg::STATUS_NOPK;
            rsp_amplitude <= prev_amp;
         end else begin
            rsp_status    <= msp2p_pkg::STATUS_OK;
            rsp_amplitude <= new_amp;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(WINDOW_SAMPLES))
      else $error("fill count beyond window");
   a_zero_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.test |-> (zeros_ff <= ZW'(ZERO_LIMIT)))
      else $error("zero count past limit");
   a_read_in_window: assert property (@(posedge clock) disable iff (reset)
      (cmd.fetch && !stat.fetch_done && fidx_ff < 3'd6) |-> (32'(rd_k) < 32'(n_ff)))
      else $error("scan read past window");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

// Scoreboard for the peak-to-peak detector. It keeps its own copy of the
// window being filled, the per-channel amplitudes and the skip setting, and
// computes the response that each request marked last must produce.
class p2p_scoreboard;
   logic [11:0] window_buf [64];
   int unsigned window_len;
   logic [11:0] chan_amp [3];
   logic [5:0]  skip_reg;
   int unsigned errors;
   logic [1:0]  exp_chan [$];
   logic [11:0] exp_amp [$];
   logic [1:0]  exp_status [$];

   function new();
      window_len = 0;
      errors = 0;
      skip_reg = 6'd2;
      foreach (chan_amp[i]) chan_amp[i] = '0;
   endfunction

   function int unsigned smooth(int unsigned k);
      return window_buf[k] + window_buf[k+1] + window_buf[k+2] + window_buf[k+3];
   endfunction

   // Scans the window; returns the status and sets amp on success.
   function logic [1:0] scan_window(int unsigned n, output logic [11:0] amp);
      int unsigned step, k, zeros, nmin, nmax, smin, smax, a, b, c, amin, amax;
      step = (skip_reg < msp2p_pkg::MIN_SKIP) ? msp2p_pkg::MIN_SKIP : skip_reg;
      k = msp2p_pkg::SCAN_START;
      zeros = 0; nmin = 0; nmax = 0; smin = 0; smax = 0;
      amp = '0;
      while (k + 4 < n) begin
         if (window_buf[k+1] == 0) begin
            zeros++;
            if (zeros > msp2p_pkg::ZERO_LIMIT) return msp2p_pkg::STATUS_ZEROS;
         end
         a = smooth(k - 1);
         b = smooth(k);
         c = smooth(k + 1);
         if (a >= b && c >= b) begin
            nmin++; smin += b; k += step + 1;
         end else if (a <= b && c <= b) begin
            nmax++; smax += b; k += step + 1;
         end else begin
            k++;
         end
      end
      if (nmin == 0 || nmax == 0) return msp2p_pkg::STATUS_NOPK;
      amin = smin / nmin;
      amax = smax / nmax;
      amp = (amax > amin) ? 12'((amax - amin) >> 2) : 12'd0;
      return msp2p_pkg::STATUS_OK;
   endfunction

   function void note_request(logic [1:0] ch, logic [11:0] smp, logic last);
      logic [11:0] amp;
      logic [11:0] prev;
      logic [1:0]  st;
      if (window_len < msp2p_pkg::WINDOW_SAMPLES) begin
         window_buf[window_len] = smp;
         window_len++;
      end
      if (!last) return;
      prev = (ch < msp2p_pkg::CHANNELS) ? chan_amp[ch] : 12'd0;
      st = scan_window(window_len, amp);
      window_len = 0;
      if (st == msp2p_pkg::STATUS_OK) begin
         if (ch < msp2p_pkg::CHANNELS) chan_amp[ch] = amp;
      end else begin
         amp = prev;
      end
      exp_chan.push_back(ch);
      exp_amp.push_back(amp);
      exp_status.push_back(st);
   endfunction

   function void report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endfunction

   function void check_response(logic [1:0] ch, logic [11:0] amp, logic [1:0] st);
      logic [1:0]  ech;
      logic [11:0] eamp;
      logic [1:0]  est;
      if (exp_chan.size() == 0) begin
         report($sformatf("unexpected response ch=%0d amp=%0d st=%0d", ch, amp, st));
         return;
      end
      ech = exp_chan.pop_front();
      eamp = exp_amp.pop_front();
      est = exp_status.pop_front();
      if (ch !== ech) report($sformatf("channel %0d, wanted %0d", ch, ech));
      if (amp !== eamp) report($sformatf("amplitude %0d, wanted %0d", amp, eamp));
      if (st !== est) report($sformatf("status %0d, wanted %0d", st, est));
   endfunction

   function int pending();
      return exp_chan.size();
   endfunction
endclass

module tb;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_channel;
   logic [11:0] req_sample;
   logic        req_last_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_result_channel;
   logic [11:0] rsp_amplitude;
   logic [1:0]  rsp_status;
   logic        csr_wr_en;
   logic [5:0]  csr_skip_after_peak;

   p2p_scoreboard board;
   int unsigned   cycle_count;
   // While set, the response side holds stall high for a long stretch.
   logic          hold_off;
   // Maximum stall gap drawn by the response side; zero gives a stretch
   // with no stalls at all.
   int unsigned   rsp_gap_max;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   moving_sum_peak_to_peak_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_channel         (req_channel),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_channel  (rsp_result_channel),
      .rsp_amplitude       (rsp_amplitude),
      .rsp_status          (rsp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_skip_after_peak (csr_skip_after_peak)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // All inputs start at known values while reset is held.
   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_channel = '0;
      req_sample = '0;
      req_last_sample = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_skip_after_peak = 6'd2;
      hold_off = 1'b0;
      rsp_gap_max = 19;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Global watchdog. The slowest legal run is far below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end
   initial cycle_count = 0;

   // Response side: accepted responses are checked at the clock edge, and the
   // stall line is redrawn after each response. Stall is raised for a random
   // gap whether or not a response is offered, so gaps land on every phase.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_result_channel, rsp_amplitude, rsp_status);
      end
   end

   initial begin : rsp_driver
      int unsigned gap;
      @(negedge reset);
      forever begin
         gap = (rsp_gap_max == 0) ? 0 : $urandom_range(rsp_gap_max, 0);
         if (gap != 0 || hold_off) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // Offers one request and waits until it is accepted; the payload holds
   // steady while the block stalls.
   task automatic send_request(input logic [1:0] ch, input logic [11:0] smp,
                               input logic last, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_sample <= smp;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(ch, smp, last);
   endtask

   // Writes the skip register while the block is idle: every expected
   // response has arrived, and the scan of a window cannot still be running.
   task automatic write_skip(input logic [5:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_skip_after_peak <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.skip_reg = value;
   endtask

   // Sends one window. Shapes: 0 square wave with noise, 1 random noise,
   // 2 many zeros, 3 flat, 4 one full-scale sample then two zeros, repeating.
   task automatic send_window(input logic [1:0] ch, input int unsigned len,
                              input int unsigned shape, input int unsigned gap_max);
      int unsigned period, base, ampl, i;
      logic [11:0] smp;
      period = $urandom_range(16, 4);
      base = $urandom_range(3000, 1000);
      ampl = $urandom_range(1000, 0);
      for (i = 0; i < len; i++) begin
         case (shape)
            0: smp = 12'(base + ((i % period) < period / 2 ? ampl : 0)
                         + $urandom_range(40, 0));
            1: smp = 12'($urandom());
            2: smp = ($urandom_range(3, 0) != 0) ? 12'd0 : 12'($urandom());
            3: smp = 12'(base);
            default: smp = (i % 3 == 0) ? 12'hFFF : 12'h000;
         endcase
         send_request(ch, smp, i == len - 1,
                      gap_max == 0 ? 0 : $urandom_range(gap_max, 0));
      end
   endtask

   initial begin : stimulus
      int unsigned w, sent, len, shape;
      @(negedge reset);
      @(posedge clock);

      // Directed part: short windows, the channel extremes including the
      // unused channel three, flat runs, zero aborts, and all-ones samples.
      send_window(2'd0, 1, 1, 0);
      send_window(2'd1, 7, 0, 0);
      send_window(2'd2, 8, 4, 0);
      send_window(2'd3, 12, 0, 0);
      send_window(2'd0, 24, 2, 0);
      send_window(2'd1, 12, 3, 0);
      write_skip(6'd0);
      send_window(2'd2, 20, 4, 3);
      write_skip(6'd63);
      send_window(2'd0, 24, 0, 0);

      // Long hold-off on the response side while requests keep coming, so the
      // block fills up and stalls its input. The hold-off is timed in its own
      // process while the windows go out one after another.
      fork
         begin
            send_window(2'd1, 30, 0, 0);
            send_window(2'd2, 30, 0, 0);
            send_window(2'd0, 30, 0, 0);
         end
         begin
            hold_off = 1'b1;
            repeat (1500) @(posedge clock);
            hold_off = 1'b0;
         end
      join

      // Random part: mostly well-formed waves, some noise and broken windows.
      sent = 0;
      w = 0;
      while (sent < 2000) begin
         if (w % 12 == 0)
            write_skip(w % 36 == 0 ? 6'd1 : (w % 24 == 0 ? 6'd56 : 6'($urandom_range(8, 2))));
         rsp_gap_max = (w % 10 < 3) ? 0 : 19;
         len = ($urandom_range(9, 0) == 0) ? $urandom_range(90, 65) : $urandom_range(64, 1);
         shape = ($urandom_range(9, 0) < 6) ? 0 : $urandom_range(4, 1);
         send_window(2'($urandom_range(3, 0)), len, shape, (w % 5 == 0) ? 0 : 19);
         sent += len;
         w++;
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
